@@ src/dptw_pkg.sv @@
// ----------------------------------------------------------------------------
// dptw_pkg
// Shared constants, types and helper functions of the demand page table walker.
// ----------------------------------------------------------------------------
package dptw_pkg;

  localparam int ADDR_BITS       = 32;
  localparam int ENTRY_OVH       = 3;      // log2 of the 8-byte table entry
  localparam int LVL_MAX         = 13;     // widest per-level index (page shift 16)
  localparam int PS_W            = 5;
  localparam int STORE_WORDS_DEF = 65536;
  localparam int FRAME_COUNT_DEF = 65536;

  localparam logic [PS_W-1:0] PS_MIN   = 5'd4;
  localparam logic [PS_W-1:0] PS_MAX   = 5'd16;
  localparam logic [PS_W-1:0] PS_RESET = 5'd12;

  localparam int VPN_W      = 28;
  localparam int FRAME_W    = 16;
  localparam int CNT_W      = 17;
  localparam int OUT_DATA_W = 80;

  // One walk step handed to the index unit
  typedef struct packed {
    logic [PS_W-1:0] shift;     // right shift of the address for this level
    logic [3:0]      idx_bits;  // index width of this level (root may be narrower)
    logic [3:0]      lvl_bits;  // index width of a full table
  } dptw_step_t;

  function automatic logic [PS_W-1:0] clamp_shift(input logic [PS_W-1:0] v);
    logic [PS_W-1:0] r;
    r = v;
    if (v < PS_MIN) r = PS_MIN;
    if (v > PS_MAX) r = PS_MAX;
    return r;
  endfunction

  // Bits left for the root table once all lower levels take a full index
  function automatic logic [3:0] root_bits(input logic [PS_W-1:0] s);
    logic [3:0] r;
    unique case (s)
      5'd4:    r = 4'd1;
      5'd5:    r = 4'd1;
      5'd6:    r = 4'd2;
      5'd7:    r = 4'd1;
      5'd8:    r = 4'd4;
      5'd9:    r = 4'd5;
      5'd10:   r = 4'd1;
      5'd11:   r = 4'd5;
      5'd12:   r = 4'd2;
      5'd13:   r = 4'd9;
      5'd14:   r = 4'd7;
      5'd15:   r = 4'd5;
      5'd16:   r = 4'd3;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

  function automatic logic [PS_W-1:0] first_shift(input logic [PS_W-1:0] s);
    return PS_W'(ADDR_BITS - int'(root_bits(s)));
  endfunction

endpackage

@@ src/dptw_index_unit.sv @@
// ----------------------------------------------------------------------------
// dptw_index_unit
// Shared shift unit: forms the table store word of one walk level.
// ----------------------------------------------------------------------------
module dptw_index_unit #(
  parameter int unsigned STORE_WORDS = dptw_pkg::STORE_WORDS_DEF
) (
  input  logic [dptw_pkg::ADDR_BITS-1:0]   vaddr,
  input  dptw_pkg::dptw_step_t             step,
  input  logic [$clog2(STORE_WORDS)-1:0]   slot,
  output logic [$clog2(STORE_WORDS)-1:0]   word_addr,
  output logic                             in_range
);
  import dptw_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);
  localparam int WW = AW + LVL_MAX;
  localparam logic [WW-1:0] LIMIT = WW'(STORE_WORDS);

  logic [ADDR_BITS-1:0] shifted;
  logic [LVL_MAX:0]     mask_x;
  logic [LVL_MAX-1:0]   idx;
  logic [WW-1:0]        wide;

  assign shifted   = vaddr >> step.shift;
  assign mask_x    = ((LVL_MAX+1)'(1) << step.idx_bits) - (LVL_MAX+1)'(1);
  assign idx       = shifted[LVL_MAX-1:0] & mask_x[LVL_MAX-1:0];
  // table slot selects the block of words, the index the word inside it
  assign wide      = (WW'(slot) << step.lvl_bits) | WW'(idx);
  assign in_range  = (wide < LIMIT);
  assign word_addr = wide[AW-1:0];

endmodule

@@ src/demand_page_table_walker_top.sv @@
// ----------------------------------------------------------------------------
// demand_page_table_walker_top
// Multi-level page table walk with on-demand table and frame allocation.
// ----------------------------------------------------------------------------
//
// Channel  | Ports            | Direction | Payload
// ---------+------------------+-----------+-----------------------------------
// input    | in_tvalid/tready | slave     | in_tdata: virtual_address[31:0]
// result   | out_tvalid/tready| master    | out_tdata: see port comment
// config   | cfg_wr_en        | write     | cfg_wr_data: page_shift[4:0]
//
// Walk: a request steps through L table levels, L = number of table levels
//   (2 at page shift 13..16, up to 28 at page shift 4), then ST_DONE.
//   Each level does one store read (registered) in ST_LOOKUP and a
//   decide/allocate step in ST_CHECK; one shared index unit serves all levels.
// Reset and every page_shift write start a clearing pass over every word
//   of the table store; no request is taken meanwhile.
// Stalls: a finished result waits in the output register; the next request
//   is accepted meanwhile and only its completion waits for out_tready.
// ----------------------------------------------------------------------------
module demand_page_table_walker_top #(
  parameter int unsigned STORE_WORDS = dptw_pkg::STORE_WORDS_DEF,
  parameter int unsigned FRAME_COUNT = dptw_pkg::FRAME_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // virtual_address[31:0]
  input  logic [dptw_pkg::ADDR_BITS-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // page_number[27:0], phys_frame[43:28], newly_mapped[44],
  // table_count[61:45], frames_used[78:62], out_of_space[79]
  output logic [dptw_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_wr_en,
  input  logic [dptw_pkg::PS_W-1:0]          cfg_wr_data
);
  import dptw_pkg::*;

  localparam int AW   = $clog2(STORE_WORDS);
  localparam int FW   = $clog2(FRAME_COUNT);
  localparam int VW   = (AW > FW) ? AW : FW;        // entry payload: slot or frame
  localparam int NF_W = $clog2(FRAME_COUNT + 1);
  localparam int TU_W = $clog2(STORE_WORDS + 1);
  localparam logic [NF_W-1:0] FRAME_LIMIT = NF_W'(FRAME_COUNT);
  localparam logic [AW-1:0]   CLEAR_LAST  = AW'(STORE_WORDS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOOKUP = 5'b00100,
    ST_CHECK  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [PS_W-1:0]       page_shift_r, page_shift_nxt;
  logic [AW-1:0]         clear_cnt_r, clear_cnt_nxt;
  logic [NF_W-1:0]       next_frame_r, next_frame_nxt;
  logic [TU_W-1:0]       tables_used_r, tables_used_nxt;
  logic [ADDR_BITS-1:0]  vaddr_r, vaddr_nxt;
  logic [PS_W-1:0]       shift_r, shift_nxt;
  logic                  is_root_r, is_root_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  logic [VW-1:0]         frame_r, frame_nxt;
  logic                  fresh_r, fresh_nxt;
  logic                  full_r, full_nxt;
  logic [AW-1:0]         waddr_r, waddr_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [VW:0]           rd_data_r;

  logic [VW:0]           store_mem [STORE_WORDS];
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr;
  logic [VW:0]           mem_wdata;

  dptw_step_t            step;
  logic [3:0]            lvl_bits;
  logic [AW-1:0]         word_addr;
  logic                  in_range;
  logic [TU_W-1:0]       capacity;
  logic                  at_leaf;
  logic                  entry_valid;
  logic [VW-1:0]         entry_val;
  logic                  frame_free;
  logic [VPN_W-1:0]      vpn;

  assign lvl_bits      = 4'(page_shift_r - PS_W'(ENTRY_OVH));
  assign step.shift    = shift_r;
  assign step.lvl_bits = lvl_bits;
  assign step.idx_bits = is_root_r ? root_bits(page_shift_r) : lvl_bits;

  dptw_index_unit #(
    .STORE_WORDS (STORE_WORDS)
  ) u_index (
    .vaddr     (vaddr_r),
    .step      (step),
    .slot      (slot_r),
    .word_addr (word_addr),
    .in_range  (in_range)
  );

  assign capacity    = TU_W'(STORE_WORDS >> lvl_bits);
  assign at_leaf     = (shift_r == page_shift_r);
  assign entry_valid = rd_data_r[VW];
  assign entry_val   = rd_data_r[VW-1:0];
  assign frame_free  = (next_frame_r < FRAME_LIMIT);
  assign vpn         = VPN_W'(vaddr_r >> page_shift_r);

  assign in_tready   = (state_r == ST_IDLE);
  assign out_tvalid  = out_tvalid_r;
  assign out_tdata   = out_tdata_r;

  always_comb begin
    state_nxt       = state_r;
    page_shift_nxt  = page_shift_r;
    clear_cnt_nxt   = clear_cnt_r;
    next_frame_nxt  = next_frame_r;
    tables_used_nxt = tables_used_r;
    vaddr_nxt       = vaddr_r;
    shift_nxt       = shift_r;
    is_root_nxt     = is_root_r;
    slot_nxt        = slot_r;
    frame_nxt       = frame_r;
    fresh_nxt       = fresh_r;
    full_nxt        = full_r;
    waddr_nxt       = waddr_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_tdata_nxt   = out_tdata_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = waddr_r;
    mem_wdata       = '0;

    unique case (state_r)
      ST_CLEAR: begin
        // sweep the store, one word a cycle
        mem_we        = 1'b1;
        mem_waddr     = clear_cnt_r;
        clear_cnt_nxt = clear_cnt_r + AW'(1);
        if (clear_cnt_r == CLEAR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          vaddr_nxt   = in_tdata;
          shift_nxt   = first_shift(page_shift_r);
          is_root_nxt = 1'b1;
          slot_nxt    = '0;
          frame_nxt   = '0;
          fresh_nxt   = 1'b0;
          full_nxt    = 1'b0;
          state_nxt   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (in_range) begin
          mem_re    = 1'b1;
          waddr_nxt = word_addr;
          state_nxt = ST_CHECK;
        end else begin
          full_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_CHECK: begin
        priority if (entry_valid && at_leaf) begin
          frame_nxt = entry_val;
          state_nxt = ST_DONE;
        end else if (entry_valid) begin
          slot_nxt    = AW'(entry_val);
          shift_nxt   = shift_r - {1'b0, lvl_bits};
          is_root_nxt = 1'b0;
          state_nxt   = ST_LOOKUP;
        end else if (at_leaf && frame_free) begin
          // map a fresh frame to the page
          mem_we         = 1'b1;
          mem_wdata      = {1'b1, VW'(next_frame_r)};
          frame_nxt      = VW'(next_frame_r);
          fresh_nxt      = 1'b1;
          next_frame_nxt = next_frame_r + NF_W'(1);
          state_nxt      = ST_DONE;
        end else if (!at_leaf && frame_free && (tables_used_r < capacity)) begin
          // hand out the next table slot, it owns a frame too
          mem_we          = 1'b1;
          mem_wdata       = {1'b1, VW'(tables_used_r)};
          slot_nxt        = AW'(tables_used_r);
          tables_used_nxt = tables_used_r + TU_W'(1);
          next_frame_nxt  = next_frame_r + NF_W'(1);
          shift_nxt       = shift_r - {1'b0, lvl_bits};
          is_root_nxt     = 1'b0;
          state_nxt       = ST_LOOKUP;
        end else begin
          full_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {full_r,
                            CNT_W'(next_frame_r),
                            CNT_W'(tables_used_r),
                            fresh_r && !full_r,
                            full_r ? FRAME_W'(0) : FRAME_W'(frame_r),
                            vpn};
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    // new page size: new layout, drop every table
    if (cfg_wr_en) begin
      page_shift_nxt  = clamp_shift(cfg_wr_data);
      clear_cnt_nxt   = '0;
      next_frame_nxt  = NF_W'(1);
      tables_used_nxt = TU_W'(1);
      state_nxt       = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      page_shift_r  <= PS_RESET;
      clear_cnt_r   <= '0;
      next_frame_r  <= NF_W'(1);
      tables_used_r <= TU_W'(1);
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      page_shift_r  <= page_shift_nxt;
      clear_cnt_r   <= clear_cnt_nxt;
      next_frame_r  <= next_frame_nxt;
      tables_used_r <= tables_used_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vaddr_r     <= vaddr_nxt;
    shift_r     <= shift_nxt;
    is_root_r   <= is_root_nxt;
    slot_r      <= slot_nxt;
    frame_r     <= frame_nxt;
    fresh_r     <= fresh_nxt;
    full_r      <= full_nxt;
    waddr_r     <= waddr_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // Table store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= store_mem[word_addr];
    end
  end

  // Frame counter only grows between layout changes
  a_frames_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !cfg_wr_en) |=> (next_frame_r >= $past(next_frame_r)))
    else $error("frame counter went backward");

  // Every table except the root holds a frame of its own
  a_tables_have_frames: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(tables_used_r) <= int'(next_frame_r)))
    else $error("more tables than frames");

  // A walk that ran out of room reports no frame and no new mapping
  a_full_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[OUT_DATA_W-1]) |-> (out_tdata_r[44:28] == '0))
    else $error("out of space result carries a mapping");

endmodule
